// File: design/sdrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdrt_pkg;
  localparam int TableDepthDef = 64;
  localparam int RecW = 32 + 32 + 1 + 6 * 32;

  typedef enum logic [2:0] {
    MODE_MARK  = 3'd0,
    MODE_BOX   = 3'd1,
    MODE_QUERY = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_CLALL = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0]        key;
    logic [31:0]        flags;
    logic               bvalid;
    logic signed [31:0] xmin;
    logic signed [31:0] ymin;
    logic signed [31:0] zmin;
    logic signed [31:0] xmax;
    logic signed [31:0] ymax;
    logic signed [31:0] zmax;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SWAIT, S_SCMP, S_DECIDE, S_SHRD, S_SHWAIT, S_SHWR,
    S_UPWAIT, S_UPD, S_OUT
  } state_t;

  function automatic logic [31:0] expand_flags(input logic [31:0] f);
    logic [31:0] r;
    r = f;
    if (f[0]) r = r | 32'h1e;
    if (f[1]) r = r | 32'h1c;
    if (f[2]) r = r | 32'h08;
    return r;
  endfunction
endpackage
`default_nettype wire

// File: design/sdrt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sdrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
  input  wire logic [Width-1:0]                         wdata,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
  output logic      [Width-1:0]                         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/sorted_dirty_record_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted dirty-record table.
// Command channel: in_* fields are taken when start is high and busy is low.
// One result per command on out_* with out_valid high for one cycle; the
// receiver cannot stall, the result is simply presented once.
// Records live in one RAM of TABLE_DEPTH rows (key, flags, box), sorted by key.
// A single read/compare datapath does all work under one sequencer:
//   search: lower-bound binary search, a read, wait and compare per probe, log2(n)+1 probes.
//   insert: each later row is moved up by one, with a read, wait and write per row moved.
//   update: row read in S_DECIDE and S_UPWAIT, written in S_UPD; result in the cycle after.
// Clear all and ignored commands go straight from S_IDLE to S_OUT.
// Reset empties the table (entry count to zero); no clearing pass is needed
// since rows at or above the count are never used.
module sorted_dirty_record_table_unit #(
  parameter int TABLE_DEPTH = sdrt_pkg::TableDepthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic [31:0]        in_record_id,
  input  wire logic [31:0]        in_flags,
  input  wire logic signed [31:0] in_box_x_a,
  input  wire logic signed [31:0] in_box_y_a,
  input  wire logic signed [31:0] in_box_z_a,
  input  wire logic signed [31:0] in_box_x_b,
  input  wire logic signed [31:0] in_box_y_b,
  input  wire logic signed [31:0] in_box_z_b,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic [31:0]             out_flags_out,
  output logic                    out_box_valid,
  output logic signed [31:0]      out_out_x_min,
  output logic signed [31:0]      out_out_y_min,
  output logic signed [31:0]      out_out_z_min,
  output logic signed [31:0]      out_out_x_max,
  output logic signed [31:0]      out_out_y_max,
  output logic signed [31:0]      out_out_z_max
);
  import sdrt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, lo_r, lo_nxt, hi_r, hi_nxt, ptr_r, ptr_nxt;
  logic [2:0] mode_r;
  logic [31:0] id_r, fl_r;
  logic signed [31:0] xa_r, ya_r, za_r, xb_r, yb_r, zb_r;
  logic [1:0] st_r, st_nxt;
  logic found_r, found_nxt;
  rec_t res_r, res_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  rec_t wrec, rrec;
  logic [CW-1:0] mid;
  logic signed [31:0] x0, x1, y0, y1, z0, z1;

  sdrt_ram #(.Width(RecW), .Depth(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec), .raddr(raddr), .rdata(rrec)
  );

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign x0 = (xb_r < xa_r) ? xb_r : xa_r;
  assign x1 = (xb_r < xa_r) ? xa_r : xb_r;
  assign y0 = (yb_r < ya_r) ? yb_r : ya_r;
  assign y1 = (yb_r < ya_r) ? ya_r : yb_r;
  assign z0 = (zb_r < za_r) ? zb_r : za_r;
  assign z1 = (zb_r < za_r) ? za_r : zb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    ptr_r <= ptr_nxt;
    st_r <= st_nxt;
    found_r <= found_nxt;
    res_r <= res_nxt;
    if (start && !busy) begin
      mode_r <= in_mode;
      id_r <= in_record_id;
      fl_r <= in_flags;
      xa_r <= in_box_x_a; ya_r <= in_box_y_a; za_r <= in_box_z_a;
      xb_r <= in_box_x_b; yb_r <= in_box_y_b; zb_r <= in_box_z_b;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    ptr_nxt = ptr_r;
    st_nxt = st_r;
    found_nxt = found_r;
    res_nxt = res_r;
    we = 1'b0;
    waddr = ptr_r[AW-1:0];
    wrec = res_r;
    raddr = ptr_r[AW-1:0];
    busy = (state_r != S_IDLE);
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          found_nxt = 1'b0;
          res_nxt = '0;
          lo_nxt = '0;
          hi_nxt = count_r;
          st_nxt = ST_MISS;
          if (in_mode == MODE_CLALL) begin
            count_nxt = '0;
            st_nxt = ST_DONE;
            state_nxt = S_OUT;
          end else if (in_mode > MODE_CLALL || in_record_id == '0 ||
                       (in_mode <= MODE_BOX && in_flags == '0)) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          raddr = mid[AW-1:0];
          state_nxt = S_SWAIT;
        end else begin
          ptr_nxt = lo_r;
          state_nxt = S_DECIDE;
        end
      end
      S_SWAIT: begin
        raddr = mid[AW-1:0];
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rrec.key >= id_r) hi_nxt = mid;
        else lo_nxt = mid + 1'b1;
        state_nxt = S_SRCH;
      end
      S_DECIDE: begin
        // read row lo; rrec valid next cycle if lo < count
        raddr = lo_r[AW-1:0];
        state_nxt = S_UPWAIT;
      end
      S_UPWAIT: begin
        raddr = lo_r[AW-1:0];
        if (lo_r < count_r && rrec.key == id_r) begin
          state_nxt = S_UPD;
        end else if (mode_r > MODE_BOX) begin
          state_nxt = S_OUT;
        end else if (count_r == CW'(TABLE_DEPTH)) begin
          st_nxt = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = count_r;
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        // move row ptr-1 to ptr, down to lo
        if (ptr_r == lo_r) begin
          we = 1'b1;
          waddr = lo_r[AW-1:0];
          wrec = '0;
          wrec.key = id_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_DECIDE;
        end else begin
          raddr = AW'(ptr_r - 1'b1);
          state_nxt = S_SHWAIT;
        end
      end
      S_SHWAIT: begin
        raddr = AW'(ptr_r - 1'b1);
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        we = 1'b1;
        waddr = ptr_r[AW-1:0];
        wrec = rrec;
        ptr_nxt = ptr_r - 1'b1;
        state_nxt = S_SHRD;
      end
      S_UPD: begin
        wrec = rrec;
        waddr = lo_r[AW-1:0];
        st_nxt = ST_DONE;
        unique case (mode_r)
          MODE_QUERY: begin
            found_nxt = 1'b1;
            res_nxt = rrec;
          end
          MODE_CLEAR: begin
            we = 1'b1;
            wrec.flags = rrec.flags & ~fl_r;
            if (wrec.flags == '0) wrec.bvalid = 1'b0;
          end
          default: begin
            we = 1'b1;
            wrec.flags = rrec.flags | expand_flags(fl_r);
            if (mode_r == MODE_BOX) begin
              wrec.bvalid = 1'b1;
              if (!rrec.bvalid) begin
                wrec.xmin = x0; wrec.ymin = y0; wrec.zmin = z0;
                wrec.xmax = x1; wrec.ymax = y1; wrec.zmax = z1;
              end else begin
                if (x0 < rrec.xmin) wrec.xmin = x0;
                if (y0 < rrec.ymin) wrec.ymin = y0;
                if (z0 < rrec.zmin) wrec.zmin = z0;
                if (x1 > rrec.xmax) wrec.xmax = x1;
                if (y1 > rrec.ymax) wrec.ymax = y1;
                if (z1 > rrec.zmax) wrec.zmax = z1;
              end
            end
          end
        endcase
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_status = st_r;
  assign out_found = found_r;
  assign out_flags_out = res_r.flags;
  assign out_box_valid = res_r.bvalid;
  assign out_out_x_min = res_r.xmin;
  assign out_out_y_min = res_r.ymin;
  assign out_out_z_min = res_r.zmin;
  assign out_out_x_max = res_r.xmax;
  assign out_out_y_max = res_r.ymax;
  assign out_out_z_max = res_r.zmax;
endmodule
`default_nettype wire
